>>> rtl/tgs_pkg.sv
// tgs_pkg: shared types, widths and codes of the trilinear gradient splat block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package tgs_pkg;

  // grid store geometry
  localparam int GRID_WORDS = 4096;
  localparam int ADDR_W     = $clog2(GRID_WORDS);

  // fixed point formats
  localparam int FRAC   = 16;
  localparam int POS_W  = 18;
  localparam int VAL_W  = 17;
  localparam int ACC_W  = 48;
  localparam int SCL_W  = 32;
  localparam int SIZE_W = 9;
  localparam int T_W    = 26;
  localparam int W_W    = FRAC + 1;

  localparam logic [W_W-1:0] ONE_Q  = W_W'(1) << FRAC;
  localparam logic [W_W-1:0] HALF_Q = W_W'(1) << (FRAC - 1);

  // command codes
  localparam logic [1:0] CMD_WR_VAL = 2'd0;
  localparam logic [1:0] CMD_WR_ACC = 2'd1;
  localparam logic [1:0] CMD_RD_ACC = 2'd2;
  localparam logic [1:0] CMD_SPLAT  = 2'd3;

  // combine modes
  localparam logic [1:0] MODE_MIN  = 2'd1;
  localparam logic [1:0] MODE_PROD = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_SKIP    = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  // one queued transaction, axis products already formed
  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic [ACC_W-1:0]  wval;
    logic [SCL_W-1:0]  scale;
    logic [VAL_W-1:0]  target;
    logic [T_W-1:0]    tx;
    logic [T_W-1:0]    ty;
    logic [T_W-1:0]    tz;
  } item_t;

  // per-axis cell pair and weights
  typedef struct packed {
    logic [7:0]     c0;
    logic [7:0]     c1;
    logic [W_W-1:0] w0;
    logic [W_W-1:0] w1;
  } axis_res_t;

endpackage
`default_nettype wire

>>> rtl/trilinear_gradient_splat_top.sv
// trilinear_gradient_splat_top: configuration registers, front queue and
// execution back end; uses tgs_pkg, tgs_front and tgs_back
//
// usage: a transaction is taken when start is high and busy is low. busy rises
// only while the two-entry queue in front of the execution unit is full.
// every transaction gives exactly one result, shown for one cycle with
// out_valid high; the receiver cannot hold it off.
// a grid write answers in the cycle after leaving the queue; an accumulator
// read passes through the readout state. a splat sets up the axes, forms for
// each of 8 corners the weights, index and value fetch, interpolates, runs a
// bit-serial divide in product mode and ends with 8 read-modify-writes on the
// single-port accumulator grid; one stopped by min gating or a zero value ends
// after the interpolation. the next transaction leaves the queue only once
// the last is done, as set by the single-port grids and shared corner sequencer.
// cfg_we writes register cfg_index (0..2 sizes, 3 combine mode) at once; the
// user must use it only while the block is idle; the block does not enforce it.
// reset clears the queue and the sequencer and sets sizes to 16, mode to 0;
// grid contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module trilinear_gradient_splat_top
  import tgs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [11:0] in_address,
  input  wire logic [47:0] in_write_value,
  input  wire logic [17:0] in_pos_x,
  input  wire logic [17:0] in_pos_y,
  input  wire logic [17:0] in_pos_z,
  input  wire logic [31:0] in_scale,
  input  wire logic [16:0] in_target_u,
  output logic             out_valid,
  output logic [47:0]      out_read_value,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [1:0]        mode_r;
  logic [SIZE_W-1:0] nx, ny, nz;
  logic              q_valid, q_pop;
  item_t             q_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_W'(16);
      size_y_r <= SIZE_W'(16);
      size_z_r <= SIZE_W'(16);
      mode_r   <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_data;
        REG_SIZE_Y: size_y_r <= cfg_data;
        REG_SIZE_Z: size_z_r <= cfg_data;
        REG_MODE:   mode_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, clamped to 1..256
  function automatic logic [SIZE_W-1:0] eff(input logic [SIZE_W-1:0] s);
    if (s == '0) begin
      return SIZE_W'(1);
    end else if (s > SIZE_W'(256)) begin
      return SIZE_W'(256);
    end
    return s;
  endfunction

  assign nx = eff(size_x_r);
  assign ny = eff(size_y_r);
  assign nz = eff(size_z_r);

  tgs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_address     (in_address),
    .in_write_value (in_write_value),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_scale       (in_scale),
    .in_target_u    (in_target_u),
    .nx             (nx),
    .ny             (ny),
    .nz             (nz),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  tgs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .nx             (nx),
    .ny             (ny),
    .nz             (nz),
    .mode           (mode_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire

>>> rtl/tgs_front.sv
// tgs_front: accepts transactions, mirrors splat coordinates and scales them
// by the grid sizes, then holds them in a two-entry queue; uses tgs_pkg
`timescale 1ns / 1ps
`default_nettype none
module tgs_front
  import tgs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [11:0]       in_address,
  input  wire logic [47:0]       in_write_value,
  input  wire logic [17:0]       in_pos_x,
  input  wire logic [17:0]       in_pos_y,
  input  wire logic [17:0]       in_pos_z,
  input  wire logic [31:0]       in_scale,
  input  wire logic [16:0]       in_target_u,
  input  wire logic [SIZE_W-1:0] nx,
  input  wire logic [SIZE_W-1:0] ny,
  input  wire logic [SIZE_W-1:0] nz,
  output logic                   q_valid,
  output item_t                  q_item,
  input  wire logic              q_pop
);

  // mirror into [0,1] and multiply by the axis size
  function automatic logic [T_W-1:0] axis_t(input logic [POS_W-1:0] p,
                                            input logic [SIZE_W-1:0] n);
    logic signed [POS_W:0] rs;
    logic signed [POS_W:0] rm;
    logic signed [POS_W:0] one_s;
    one_s = (POS_W+1)'(ONE_Q);
    rs = {p[POS_W-1], p};
    if (rs < 0) begin
      rm = -rs;
    end else if (rs > one_s) begin
      rm = (one_s <<< 1) - rs;
    end else begin
      rm = rs;
    end
    if (rm < 0) begin
      rm = '0;
    end
    if (rm > one_s) begin
      rm = one_s;
    end
    return T_W'(rm[W_W-1:0]) * T_W'(n);
  endfunction

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      new_item;

  // classify and prepare the incoming transaction
  always_comb begin
    new_item.cmd    = in_cmd;
    new_item.addr   = in_address[ADDR_W-1:0];
    new_item.wval   = in_write_value;
    new_item.scale  = in_scale;
    new_item.target = in_target_u;
    new_item.tx     = axis_t(in_pos_x, nx);
    new_item.ty     = axis_t(in_pos_y, ny);
    new_item.tz     = axis_t(in_pos_z, nz);
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= new_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/tgs_back.sv
// tgs_back: executes queued transactions on the value and accumulator grids,
// sequencing corners, interpolation, bit-serial divide and saturating updates
// uses tgs_pkg
`timescale 1ns / 1ps
`default_nettype none
module tgs_back
  import tgs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SIZE_W-1:0] nx,
  input  wire logic [SIZE_W-1:0] ny,
  input  wire logic [SIZE_W-1:0] nz,
  input  wire logic [1:0]        mode,
  input  wire logic              q_valid,
  input  wire item_t             q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  output logic [47:0]            out_read_value,
  output logic [1:0]             out_status
);

  localparam int ACCS_W = 36;
  localparam int U_W    = 21;
  localparam int NUM_W  = 50;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int DM_W   = 60;
  localparam int SUM_W  = 62;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AXIS  = 4'd1;
  localparam logic [3:0] S_C0    = 4'd2;
  localparam logic [3:0] S_C1    = 4'd3;
  localparam logic [3:0] S_C2    = 4'd4;
  localparam logic [3:0] S_C3    = 4'd5;
  localparam logic [3:0] S_C4    = 4'd6;
  localparam logic [3:0] S_U     = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_A0    = 4'd9;
  localparam logic [3:0] S_A1    = 4'd10;
  localparam logic [3:0] S_A2    = 4'd11;
  localparam logic [3:0] S_A3    = 4'd12;
  localparam logic [3:0] S_RDOUT = 4'd13;

  // cell pair and weights of one axis
  function automatic axis_res_t axis_setup(input logic [T_W-1:0] t,
                                           input logic [SIZE_W-1:0] n);
    axis_res_t         r;
    logic [9:0]        x;
    logic              clamped;
    logic [W_W-1:0]    f;
    logic signed [W_W:0] d;
    x = t[T_W-1:FRAC];
    clamped = (x >= 10'(n));
    if (clamped) begin
      x = 10'(n) - 10'd1;
    end
    f = clamped ? ONE_Q : {1'b0, t[FRAC-1:0]};
    d = $signed({1'b0, f}) - $signed({1'b0, HALF_Q});
    r.c0 = x[7:0];
    if (d >= 0) begin
      r.c1 = ((x + 10'd1) >= 10'(n)) ? x[7:0] : 8'(x + 10'd1);
      r.w1 = d[W_W-1:0];
    end else begin
      r.c1 = (x == 10'd0) ? 8'd0 : 8'(x - 10'd1);
      r.w1 = W_W'(-d);
    end
    r.w0 = ONE_Q - r.w1;
    return r;
  endfunction

  logic [VAL_W-1:0]  vmem [GRID_WORDS];
  logic [ACC_W-1:0]  amem [GRID_WORDS];

  logic [3:0]        state_r, state_nxt;
  item_t             item_r;
  axis_res_t         ax_r, ay_r, az_r;
  logic [2:0]        k_r;
  logic [2*W_W-1:0]  p1_r, p2_r;
  logic [16:0]       i1_r;
  logic [ADDR_W-1:0] idx_r [8];
  logic [W_W-1:0]    cw_r [8];
  logic [VAL_W-1:0]  vdata_r;
  logic [ACC_W-1:0]  adata_r;
  logic [2*VAL_W-1:0] prod_r;
  logic [ACCS_W-1:0] acc_r;
  logic [U_W-1:0]    u_r;
  logic [NUM_W-1:0]  num_r;
  logic [U_W-1:0]    rem_r;
  logic [CNT_W-1:0]  dcnt_r;
  logic [40:0]       pa_r;
  logic [34:0]       pb_r;
  logic [24:0]       pl_r;
  logic [DM_W-1:0]   dm_r;
  logic              sat_r;
  logic              out_valid_r;
  logic [47:0]       out_read_value_r;
  logic [1:0]        out_status_r;

  // corner selections
  logic [W_W-1:0]    wxk, wyk, wzk, cwk;
  logic [7:0]        cxk, cyk, czk;
  logic [W_W-1:0]    r1;
  logic [25:0]       i2;
  logic [U_W-1:0]    u_c;
  logic [SCL_W-1:0]  mag;
  logic              neg;
  logic [U_W:0]      trial;
  logic              qbit;
  logic signed [SUM_W-1:0] a_s, delta, sum;
  logic signed [SUM_W-1:0] hi_s, lo_s;
  logic [ACC_W-1:0]  anew;
  logic              sat_now;
  logic              last_k;
  logic              skip_min, skip_zero;

  assign wxk = k_r[0] ? ax_r.w1 : ax_r.w0;
  assign wyk = k_r[1] ? ay_r.w1 : ay_r.w0;
  assign wzk = k_r[2] ? az_r.w1 : az_r.w0;
  assign cxk = k_r[0] ? ax_r.c1 : ax_r.c0;
  assign cyk = k_r[1] ? ay_r.c1 : ay_r.c0;
  assign czk = k_r[2] ? az_r.c1 : az_r.c0;
  assign cwk = cw_r[k_r];
  assign last_k = (k_r == 3'd7);

  // rounding, index and interpolation terms
  always_comb begin
    logic [2*W_W:0] t1;
    logic [ACCS_W:0] t2;
    t1  = {1'b0, p1_r} + (2*W_W+1)'(HALF_Q);
    r1  = t1[FRAC+W_W-1:FRAC];
    i2  = 26'(i1_r) * 26'(nz) + 26'(czk);
    t2  = {1'b0, acc_r} + (ACCS_W+1)'(HALF_Q);
    u_c = t2[FRAC+U_W-1:FRAC];
  end

  // scale magnitude and sign
  assign neg = item_r.scale[SCL_W-1];
  assign mag = neg ? (~item_r.scale + SCL_W'(1)) : item_r.scale;

  assign skip_min  = (mode == MODE_MIN) && (u_c != U_W'(item_r.target));
  assign skip_zero = (mode == MODE_PROD) && (u_c == '0);

  // one restoring divide step
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, u_r});

  // saturating accumulator update
  always_comb begin
    hi_s  = SUM_W'((64'd1 << (ACC_W - 1)) - 64'd1);
    lo_s  = -hi_s - SUM_W'(1);
    a_s   = SUM_W'($signed(adata_r));
    delta = neg ? -$signed(SUM_W'(dm_r)) : $signed(SUM_W'(dm_r));
    sum   = a_s + delta;
    sat_now = 1'b0;
    if (sum > hi_s) begin
      anew = hi_s[ACC_W-1:0];
      sat_now = 1'b1;
    end else if (sum < lo_s) begin
      anew = lo_s[ACC_W-1:0];
      sat_now = 1'b1;
    end else begin
      anew = sum[ACC_W-1:0];
    end
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.cmd == CMD_RD_ACC) begin
            state_nxt = S_RDOUT;
          end else if (q_item.cmd == CMD_SPLAT) begin
            state_nxt = S_AXIS;
          end
        end
      end
      S_AXIS:  state_nxt = S_C0;
      S_C0:    state_nxt = S_C1;
      S_C1:    state_nxt = S_C2;
      S_C2:    state_nxt = S_C3;
      S_C3:    state_nxt = S_C4;
      S_C4:    state_nxt = last_k ? S_U : S_C0;
      S_U: begin
        if (skip_min || skip_zero) begin
          state_nxt = S_IDLE;
        end else if (mode == MODE_PROD) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_A0;
        end
      end
      S_DIV:   state_nxt = (dcnt_r == CNT_W'(NUM_W - 1)) ? S_A0 : S_DIV;
      S_A0:    state_nxt = S_A1;
      S_A1:    state_nxt = S_A2;
      S_A2:    state_nxt = S_A3;
      S_A3:    state_nxt = last_k ? S_IDLE : S_A0;
      S_RDOUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid && (q_item.cmd == CMD_WR_VAL || q_item.cmd == CMD_WR_ACC)) begin
            out_valid_r <= 1'b1;
          end
          k_r <= 3'd0;
        end
        S_C4: k_r <= k_r + 3'd1;
        S_U: begin
          if (skip_min || skip_zero) begin
            out_valid_r <= 1'b1;
          end
        end
        S_A3: begin
          k_r <= k_r + 3'd1;
          if (last_k) begin
            out_valid_r <= 1'b1;
          end
        end
        S_RDOUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        item_r           <= q_item;
        out_read_value_r <= '0;
        out_status_r     <= ST_DONE;
        acc_r            <= '0;
        sat_r            <= 1'b0;
      end
      S_AXIS: begin
        ax_r <= axis_setup(item_r.tx, nx);
        ay_r <= axis_setup(item_r.ty, ny);
        az_r <= axis_setup(item_r.tz, nz);
      end
      S_C0: begin
        p1_r <= (2*W_W)'(wxk) * (2*W_W)'(wyk);
        i1_r <= 17'(cxk) * 17'(ny) + 17'(cyk);
      end
      S_C1: begin
        p2_r       <= (2*W_W)'(r1) * (2*W_W)'(wzk);
        idx_r[k_r] <= i2[ADDR_W-1:0];
      end
      S_C2: begin
        cw_r[k_r] <= W_W'((p2_r + (2*W_W)'(HALF_Q)) >> FRAC);
      end
      S_C3: prod_r <= (2*VAL_W)'(cwk) * (2*VAL_W)'(vdata_r);
      S_C4: acc_r  <= acc_r + ACCS_W'(prod_r);
      S_U: begin
        u_r    <= u_c;
        rem_r  <= '0;
        dcnt_r <= '0;
        if (skip_min) begin
          out_status_r <= ST_SKIP;
        end else if (skip_zero) begin
          out_status_r <= ST_ZERO;
        end
        if (mode == MODE_PROD) begin
          num_r <= NUM_W'(mag) * NUM_W'(item_r.target) + NUM_W'(u_c >> 1);
        end else begin
          num_r <= NUM_W'(mag);
        end
      end
      S_DIV: begin
        rem_r  <= qbit ? U_W'(trial - {1'b0, u_r}) : trial[U_W-1:0];
        num_r  <= {num_r[NUM_W-2:0], qbit};
        dcnt_r <= dcnt_r + CNT_W'(1);
      end
      S_A0: pa_r <= 41'(cwk) * 41'(num_r[31:8]);
      S_A1: begin
        pb_r <= 35'(cwk) * 35'(num_r[NUM_W-1:32]);
        pl_r <= 25'(cwk) * 25'(num_r[7:0]);
      end
      S_A2: begin
        dm_r <= DM_W'(pa_r) + (DM_W'(pb_r) << 24) + DM_W'((pl_r + 25'd128) >> 8);
      end
      S_A3: begin
        sat_r <= sat_r | sat_now;
        if (last_k) begin
          out_status_r <= (sat_r | sat_now) ? ST_SAT : ST_DONE;
        end
      end
      S_RDOUT: out_read_value_r <= adata_r;
      default: ;
    endcase
  end

  // value grid, single port
  always_ff @(posedge clk) begin
    if (q_pop && q_item.cmd == CMD_WR_VAL) begin
      vmem[q_item.addr] <= q_item.wval[VAL_W-1:0];
    end
    if (state_r == S_C2) begin
      vdata_r <= vmem[idx_r[k_r]];
    end
  end

  // accumulator grid, single port
  always_ff @(posedge clk) begin
    if (q_pop && q_item.cmd == CMD_WR_ACC) begin
      amem[q_item.addr] <= q_item.wval;
    end else if (state_r == S_A3) begin
      amem[idx_r[k_r]] <= anew;
    end
    if (q_pop && q_item.cmd == CMD_RD_ACC) begin
      adata_r <= amem[q_item.addr];
    end else if (state_r == S_A0) begin
      adata_r <= amem[idx_r[k_r]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire
